// ===== design/lfl_pkg.sv =====
package lfl_pkg;

    localparam int DW = 16;

    localparam logic signed [DW-1:0] DATA_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] DATA_MIN = {1'b1, {(DW-1){1'b0}}};

    // register indexes on the configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_VALUE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RANGE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_HIGH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_LOW    = 3'd5;

    localparam logic MODE_TRIM      = 1'b0;
    localparam logic MODE_THRESHOLD = 1'b1;

    typedef logic signed [DW-1:0] data_t;

    // which limit an item ends up with
    typedef enum logic [1:0] {
        SEL_WIN = 2'b00,
        SEL_HI  = 2'b01,
        SEL_LO  = 2'b10
    } lim_sel_t;

    // per-item side information carried alongside the divider
    typedef struct packed {
        data_t    request;
        lim_sel_t sel;
    } side_t;

    function automatic data_t sat_w(input logic signed [DW+1:0] x);
        data_t r;
        if (x > $signed({{2{DATA_MAX[DW-1]}}, DATA_MAX})) begin
            r = DATA_MAX;
        end else if (x < $signed({{2{DATA_MIN[DW-1]}}, DATA_MIN})) begin
            r = DATA_MIN;
        end else begin
            r = x[DW-1:0];
        end
        return r;
    endfunction

endpackage

// ===== design/linear_foldback_limiter.sv =====
// pipeline from input transfer to result: decode, multiply,
// 16 divider stages, limit select, output register
// throughput: one item per cycle unless the output stalls; the divider retires one quotient bit per stage
// each stage advances on its own, so bubbles close up and a stalled output
// still lets new items enter until the pipeline is full
// reset: synchronous active-low aresetn clears valid bits and loads register defaults
module linear_foldback_limiter (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [lfl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lfl_pkg::DW-1:0]        cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [2*lfl_pkg::DW-1:0]      s_tdata,  // request, control_value
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [lfl_pkg::DW-1:0]        m_tdata   // limited
);
    import lfl_pkg::*;

    // configuration
    logic  enable_reg;
    logic  mode_reg;
    data_t end_reg;
    data_t range_reg;
    data_t hi_reg;
    data_t lo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            mode_reg   <= MODE_TRIM;
            end_reg    <= '0;
            range_reg  <= '0;
            hi_reg     <= DATA_MAX;
            lo_reg     <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ENABLE:       enable_reg <= cfg_wdata[0];
                CFG_MODE:         mode_reg   <= cfg_wdata[0];
                CFG_END_VALUE:    end_reg    <= cfg_wdata;
                CFG_WINDOW_RANGE: range_reg  <= cfg_wdata;
                CFG_LIMIT_HIGH:   hi_reg     <= cfg_wdata;
                CFG_LIMIT_LOW:    lo_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // values derived from configuration; the user must keep them static while items flow, the block does not enforce it
    logic signed [DW:0] end_x;
    logic signed [DW:0] range_x;
    logic signed [DW:0] start_x;
    logic signed [DW:0] diff_x;
    logic signed [DW:0] diff_abs;
    logic signed [DW:0] range_abs;
    logic               rng_neg;
    logic               diff_neg;
    logic [DW-1:0]      diff_mag;
    logic [DW-1:0]      den;

    assign end_x     = {end_reg[DW-1], end_reg};
    assign range_x   = {range_reg[DW-1], range_reg};
    assign start_x   = end_x - range_x;
    assign diff_x    = {hi_reg[DW-1], hi_reg} - {lo_reg[DW-1], lo_reg};
    assign rng_neg   = range_reg[DW-1];
    assign diff_neg  = diff_x[DW];
    assign diff_abs  = diff_neg ? -diff_x : diff_x;
    assign range_abs = rng_neg ? -range_x : range_x;
    assign diff_mag  = diff_abs[DW-1:0];
    assign den       = range_abs[DW-1:0];

    // ready chain, one link per stage
    logic a_ready;
    logic b_ready;
    logic c_ready;
    logic d_ready;
    logic div_in_ready;
    logic div_out_valid;
    logic [DW-1:0] div_quo;
    side_t div_side;

    // stage a: window decode and distance into the window
    logic               a_valid_reg;
    side_t              a_side_reg;
    logic [DW-1:0]      a_dist_reg;
    logic signed [DW:0] ctl_x;
    logic signed [DW:0] dist_x;
    logic               in_win;
    logic               sel_hi;
    lim_sel_t           sel;

    assign ctl_x  = {s_tdata[2*DW-1], s_tdata[2*DW-1:DW]};
    assign in_win = rng_neg ? (ctl_x < start_x && ctl_x > end_x)
                            : (ctl_x > start_x && ctl_x < end_x);
    assign sel_hi = rng_neg ? (ctl_x >= start_x) : (ctl_x <= start_x);
    assign dist_x = rng_neg ? (ctl_x - end_x) : (end_x - ctl_x);

    always_comb begin
        priority if (in_win) begin
            sel = SEL_WIN;
        end else if (sel_hi) begin
            sel = SEL_HI;
        end else begin
            sel = SEL_LO;
        end
    end

    assign a_ready = !a_valid_reg || b_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready) begin
            a_side_reg.request <= s_tdata[DW-1:0];
            a_side_reg.sel     <= sel;
            a_dist_reg         <= dist_x[DW-1:0];
        end
    end

    // stage b: product of limit span and distance
    logic            b_valid_reg;
    side_t           b_side_reg;
    logic [2*DW-1:0] b_prod_reg;

    assign b_ready = !b_valid_reg || div_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_ready) begin
            b_side_reg <= a_side_reg;
            b_prod_reg <= diff_mag * a_dist_reg;
        end
    end

    lfl_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (b_valid_reg),
        .in_ready  (div_in_ready),
        .in_num    (b_prod_reg),
        .in_den    (den),
        .in_side   (b_side_reg),
        .out_valid (div_out_valid),
        .out_ready (c_ready),
        .out_quo   (div_quo),
        .out_side  (div_side)
    );

    // stage c: limit selection and saturation
    logic                 c_valid_reg;
    data_t                c_req_reg;
    data_t                c_lim_reg;
    logic signed [DW+1:0] quo_s;
    logic signed [DW+1:0] off_s;
    logic signed [DW+1:0] lim_raw;

    assign quo_s = {2'b00, div_quo};
    assign off_s = diff_neg ? -quo_s : quo_s;

    always_comb begin
        unique case (div_side.sel)
            SEL_WIN: lim_raw = {{2{lo_reg[DW-1]}}, lo_reg} + off_s;
            SEL_HI:  lim_raw = {{2{hi_reg[DW-1]}}, hi_reg};
            SEL_LO:  lim_raw = {{2{lo_reg[DW-1]}}, lo_reg};
            default: lim_raw = {{2{lo_reg[DW-1]}}, lo_reg};
        endcase
    end

    assign c_ready = !c_valid_reg || d_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (c_ready) begin
            c_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_ready) begin
            c_req_reg <= div_side.request;
            c_lim_reg <= sat_w(lim_raw);
        end
    end

    // stage d: trim, threshold or pass-through into the output register
    logic               m_valid_reg;
    data_t              m_data_reg;
    data_t              m_data_next;
    logic signed [DW:0] lim_x;
    logic signed [DW:0] req_x;
    logic signed [DW:0] neg_lim;

    assign lim_x   = {c_lim_reg[DW-1], c_lim_reg};
    assign req_x   = {c_req_reg[DW-1], c_req_reg};
    assign neg_lim = -lim_x;

    always_comb begin
        priority if (!enable_reg) begin
            m_data_next = c_req_reg;
        end else if (mode_reg == MODE_THRESHOLD) begin
            m_data_next = c_lim_reg;
        end else if (req_x > lim_x) begin
            m_data_next = c_lim_reg;
        end else if (req_x < neg_lim) begin
            // negating the most negative limit saturates
            m_data_next = sat_w({neg_lim[DW], neg_lim});
        end else begin
            m_data_next = c_req_reg;
        end
    end

    assign d_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (d_ready) begin
            m_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (d_ready) begin
            m_data_reg <= m_data_next;
        end
    end

    assign s_tready = a_ready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== design/lfl_divider.sv =====
module lfl_divider (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [2*lfl_pkg::DW-1:0] in_num,
    input  logic [lfl_pkg::DW-1:0]   in_den,
    input  lfl_pkg::side_t          in_side,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [lfl_pkg::DW-1:0]   out_quo,
    output lfl_pkg::side_t          out_side
);
    import lfl_pkg::*;

    // one quotient bit per stage; the upper half of the dividend is already
    // below the divisor, so it seeds the remainder directly
    logic [DW-1:0] rem_reg  [DW];
    logic [DW-1:0] low_reg  [DW];
    logic [DW-1:0] quo_reg  [DW];
    logic [DW-1:0] den_reg  [DW];
    side_t         side_reg [DW];
    logic [DW-1:0] valid_reg;
    logic [DW-1:0] rdy;

    for (genvar i = 0; i < DW; i++) begin : g_step
        logic [DW-1:0] rem_in;
        logic [DW-1:0] low_in;
        logic [DW-1:0] quo_in;
        logic [DW-1:0] den_in;
        side_t         side_in;
        logic          valid_in;
        logic          rdy_out;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;

        if (i == 0) begin : g_first
            assign rem_in   = in_num[2*DW-1:DW];
            assign low_in   = in_num[DW-1:0];
            assign quo_in   = '0;
            assign den_in   = in_den;
            assign side_in  = in_side;
            assign valid_in = in_valid;
        end else begin : g_rest
            assign rem_in   = rem_reg[i-1];
            assign low_in   = low_reg[i-1];
            assign quo_in   = quo_reg[i-1];
            assign den_in   = den_reg[i-1];
            assign side_in  = side_reg[i-1];
            assign valid_in = valid_reg[i-1];
        end

        if (i == DW-1) begin : g_last
            assign rdy_out = out_ready;
        end else begin : g_mid
            assign rdy_out = rdy[i+1];
        end

        assign rdy[i] = !valid_reg[i] || rdy_out;
        assign trial  = {rem_in, low_in[DW-1]};
        assign diff   = trial - {1'b0, den_in};
        assign ge     = (trial >= {1'b0, den_in});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (rdy[i]) begin
                valid_reg[i] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[i]) begin
                rem_reg[i]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
                low_reg[i]  <= {low_in[DW-2:0], 1'b0};
                quo_reg[i]  <= {quo_in[DW-2:0], ge};
                den_reg[i]  <= den_in;
                side_reg[i] <= side_in;
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[DW-1];
    assign out_quo   = quo_reg[DW-1];
    assign out_side  = side_reg[DW-1];

endmodule
